@@ rtl/core/radial_distance_statistics_macros.svh @@
// ----------------------------------------------------------------------------
// Radial distance statistics assertion macros
// Concurrent assertion shorthands; compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef RADIAL_DISTANCE_STATISTICS_MACROS_SVH
`define RADIAL_DISTANCE_STATISTICS_MACROS_SVH

`ifndef ASSERT_OFF
`define RDS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define RDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define RDS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define RDS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/rds_pkg.sv @@
// ----------------------------------------------------------------------------
// Radial distance statistics package
// Shared widths, constants and the command type of the shift-subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rds_pkg;

  localparam int COORD_W     = 16;
  localparam int SIDE_W      = 16;
  localparam int DIST_W      = 17;
  localparam int MIN_W       = 18;
  localparam int SUM_W       = 25;
  localparam int SQSUM_W     = 42;
  localparam int PROD_W      = 34;
  localparam int SQ_W        = 42;
  localparam int ITER_W      = 6;
  localparam int COUNT_OUT_W = 9;
  localparam int CFG_IDX_W   = 1;

  localparam logic [MIN_W-1:0] MIN_RESET = 18'd160000;

  // Iteration counts of the shared unit; operands are left-aligned in SQ_W bits.
  localparam logic [ITER_W-1:0] DIST_ITERS = 6'd17;
  localparam logic [ITER_W-1:0] MEAN_ITERS = 6'd25;
  localparam logic [ITER_W-1:0] MSQ_ITERS  = 6'd42;

  localparam logic [CFG_IDX_W-1:0] REG_CENTROID_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTROID_Y = 1'b1;

  typedef enum logic {
    OP_SQRT = 1'b0,
    OP_DIV  = 1'b1
  } op_t;

  typedef struct packed {
    logic              start;
    op_t               op;
    logic [ITER_W-1:0] iters;
  } iter_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/radial_distance_statistics.sv @@
// ----------------------------------------------------------------------------
// Radial distance statistics: distance to centroid and run statistics
// A new request is taken only once the previous result is loaded for output, so
// stalled results hold off requests; the shared shift-subtract unit makes one
// bit a cycle. Synchronous reset clears the run and the centroid.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radial_distance_statistics_macros.svh"

module radial_distance_statistics
  import rds_pkg::*;
#(
  parameter int MAX_ITEMS = 256
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // configuration
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [COORD_W-1:0]     cfg_wdata,
  // input channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [COORD_W-1:0]     in_box_center_x,
  input  wire logic [COORD_W-1:0]     in_box_center_y,
  input  wire logic [SIDE_W-1:0]      in_box_width,
  input  wire logic [SIDE_W-1:0]      in_box_height,
  input  wire logic                   in_last_in,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [DIST_W-1:0]           out_distance,
  output logic                        out_stats_valid,
  output logic [MIN_W-1:0]            out_min_distance,
  output logic [DIST_W-1:0]           out_max_distance,
  output logic [DIST_W-1:0]           out_mean_distance,
  output logic [DIST_W-1:0]           out_std_distance,
  output logic [SIDE_W-1:0]           out_largest_side,
  output logic [COUNT_OUT_W-1:0]      out_item_count,
  output logic                        out_overflow
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_SQX   = 15'h0002,
    S_SQY   = 15'h0004,
    S_DGO   = 15'h0008,
    S_DWAIT = 15'h0010,
    S_DSQ   = 15'h0020,
    S_ACC   = 15'h0040,
    S_MGO   = 15'h0080,
    S_MWAIT = 15'h0100,
    S_QGO   = 15'h0200,
    S_QWAIT = 15'h0400,
    S_VAR   = 15'h0800,
    S_SGO   = 15'h1000,
    S_SWAIT = 15'h2000,
    S_OUT   = 15'h4000
  } state_t;

  // control state
  state_t             state_r, state_nxt;
  logic [COORD_W-1:0] cx_r, cy_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SQSUM_W-1:0] sumsq_r, sumsq_nxt;
  logic [MIN_W-1:0]   min_r, min_nxt;
  logic [DIST_W-1:0]  max_r, max_nxt;
  logic [SIDE_W-1:0]  side_max_r, side_max_nxt;
  logic               ovf_r, ovf_nxt;
  logic               out_valid_r, out_valid_nxt;

  // working payload
  logic [COORD_W-1:0] dx_r, dx_nxt;
  logic [COORD_W-1:0] dy_r, dy_nxt;
  logic [SIDE_W-1:0]  side_r, side_nxt;
  logic               last_r, last_nxt;
  logic [PROD_W-1:0]  acc_r, acc_nxt;
  logic [DIST_W-1:0]  dist_r, dist_nxt;
  logic [DIST_W-1:0]  mean_r, mean_nxt;
  logic [DIST_W-1:0]  std_r, std_nxt;
  logic               load_out;

  // output payload
  logic [DIST_W-1:0]      o_dist_r;
  logic                   o_stats_r;
  logic [MIN_W-1:0]       o_min_r;
  logic [DIST_W-1:0]      o_max_r;
  logic [DIST_W-1:0]      o_mean_r;
  logic [DIST_W-1:0]      o_std_r;
  logic [SIDE_W-1:0]      o_side_r;
  logic [COUNT_OUT_W-1:0] o_count_r;
  logic                   o_ovf_r;

  // shared multiplier and shift-subtract unit
  logic [DIST_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0]  prod;
  iter_cmd_t          iter_cmd;
  logic [SQ_W-1:0]    iter_operand;
  logic               iter_busy;
  logic [SQ_W-1:0]    iter_result;
  logic [SUM_W:0]     sum_add;
  logic [SQSUM_W:0]   sumsq_add;
  logic [PROD_W-1:0]  msq;
  logic               in_accept;
  logic               stats_in_range;
  logic               partial_clear;

  assign in_accept = in_valid && !in_stall;
  assign prod      = mul_a * mul_b;
  assign sum_add   = {1'b0, sum_r} + (SUM_W + 1)'(dist_r);
  assign sumsq_add = {1'b0, sumsq_r} + (SQSUM_W + 1)'(acc_r);
  assign msq       = iter_result[PROD_W-1:0];

  rds_iter #(
    .DIV_W (CNT_W)
  ) u_iter (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (iter_cmd),
    .operand (iter_operand),
    .divisor (count_r),
    .busy    (iter_busy),
    .result  (iter_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cy_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTROID_X: cx_r <= cfg_wdata;
        REG_CENTROID_Y: cy_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    sumsq_nxt     = sumsq_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    side_max_nxt  = side_max_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    side_nxt      = side_r;
    last_nxt      = last_r;
    acc_nxt       = acc_r;
    dist_nxt      = dist_r;
    mean_nxt      = mean_r;
    std_nxt       = std_r;
    load_out      = 1'b0;
    mul_a         = {1'b0, dx_r};
    mul_b         = {1'b0, dx_r};
    iter_cmd      = '{start: 1'b0, op: OP_SQRT, iters: DIST_ITERS};
    iter_operand  = {acc_r, {(SQ_W - PROD_W){1'b0}}};

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dx_nxt   = (in_box_center_x >= cx_r) ? in_box_center_x - cx_r
                                               : cx_r - in_box_center_x;
          dy_nxt   = (in_box_center_y >= cy_r) ? in_box_center_y - cy_r
                                               : cy_r - in_box_center_y;
          side_nxt = (in_box_width > in_box_height) ? in_box_width : in_box_height;
          last_nxt = in_last_in;
          state_nxt = S_SQX;
        end
      end
      S_SQX: begin
        acc_nxt   = prod;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        mul_a     = {1'b0, dy_r};
        mul_b     = {1'b0, dy_r};
        acc_nxt   = acc_r + prod;
        state_nxt = S_DGO;
      end
      S_DGO: begin
        iter_cmd  = '{start: 1'b1, op: OP_SQRT, iters: DIST_ITERS};
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (!iter_busy) begin
          dist_nxt  = iter_result[DIST_W-1:0];
          state_nxt = S_DSQ;
        end
      end
      S_DSQ: begin
        mul_a     = dist_r;
        mul_b     = dist_r;
        acc_nxt   = prod;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        // A full run only flags the overflow; the item's distance still goes out.
        if (count_r == CNT_MAX) begin
          ovf_nxt = 1'b1;
        end else begin
          count_nxt = count_r + 1'b1;
          sum_nxt   = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
          sumsq_nxt = sumsq_add[SQSUM_W] ? {SQSUM_W{1'b1}} : sumsq_add[SQSUM_W-1:0];
          if ({1'b0, dist_r} < min_r) begin
            min_nxt = {1'b0, dist_r};
          end
          if (dist_r > max_r) begin
            max_nxt = dist_r;
          end
          if (side_r > side_max_r) begin
            side_max_nxt = side_r;
          end
        end
        state_nxt = last_r ? S_MGO : S_OUT;
      end
      S_MGO: begin
        if (count_r == '0) begin
          mean_nxt  = '0;
          std_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          iter_cmd     = '{start: 1'b1, op: OP_DIV, iters: MEAN_ITERS};
          iter_operand = {sum_r, {(SQ_W - SUM_W){1'b0}}};
          state_nxt    = S_MWAIT;
        end
      end
      S_MWAIT: begin
        if (!iter_busy) begin
          mean_nxt  = iter_result[DIST_W-1:0];
          state_nxt = S_QGO;
        end
      end
      S_QGO: begin
        iter_cmd     = '{start: 1'b1, op: OP_DIV, iters: MSQ_ITERS};
        iter_operand = sumsq_r;
        state_nxt    = S_QWAIT;
      end
      S_QWAIT: begin
        if (!iter_busy) begin
          state_nxt = S_VAR;
        end
      end
      S_VAR: begin
        // The mean of squares never exceeds the largest square, so it fits PROD_W.
        mul_a     = mean_r;
        mul_b     = mean_r;
        acc_nxt   = (msq > prod) ? msq - prod : '0;
        state_nxt = S_SGO;
      end
      S_SGO: begin
        iter_cmd  = '{start: 1'b1, op: OP_SQRT, iters: DIST_ITERS};
        state_nxt = S_SWAIT;
      end
      S_SWAIT: begin
        if (!iter_busy) begin
          std_nxt   = iter_result[DIST_W-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (last_r) begin
            count_nxt    = '0;
            sum_nxt      = '0;
            sumsq_nxt    = '0;
            min_nxt      = MIN_RESET;
            max_nxt      = '0;
            side_max_nxt = '0;
            ovf_nxt      = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      sumsq_r     <= '0;
      min_r       <= MIN_RESET;
      max_r       <= '0;
      side_max_r  <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      sumsq_r     <= sumsq_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      side_max_r  <= side_max_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    side_r <= side_nxt;
    last_r <= last_nxt;
    acc_r  <= acc_nxt;
    dist_r <= dist_nxt;
    mean_r <= mean_nxt;
    std_r  <= std_nxt;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_dist_r <= dist_r;
      if (last_r) begin
        o_stats_r <= 1'b1;
        o_min_r   <= min_r;
        o_max_r   <= max_r;
        o_mean_r  <= mean_r;
        o_std_r   <= std_r;
        o_side_r  <= side_max_r;
        o_count_r <= COUNT_OUT_W'(count_r);
        o_ovf_r   <= ovf_r;
      end else begin
        o_stats_r <= 1'b0;
        o_min_r   <= '0;
        o_max_r   <= '0;
        o_mean_r  <= '0;
        o_std_r   <= '0;
        o_side_r  <= '0;
        o_count_r <= '0;
        o_ovf_r   <= 1'b0;
      end
    end
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_distance      = o_dist_r;
  assign out_stats_valid   = o_stats_r;
  assign out_min_distance  = o_min_r;
  assign out_max_distance  = o_max_r;
  assign out_mean_distance = o_mean_r;
  assign out_std_distance  = o_std_r;
  assign out_largest_side  = o_side_r;
  assign out_item_count    = o_count_r;
  assign out_overflow      = o_ovf_r;

  assign stats_in_range = (out_mean_distance <= out_max_distance)
                       && (out_std_distance <= out_max_distance);
  assign partial_clear  = (out_item_count == '0) && !out_overflow;

  `RDS_ASSERT_IMPLY(a_iter_start_free, clk, rst_n, iter_cmd.start, !iter_busy)
  `RDS_ASSERT_NEXT(a_accept_holds_off, clk, rst_n, in_accept, in_stall && state_r == S_SQX)
  `RDS_ASSERT_IMPLY(a_stats_bounded, clk, rst_n, out_valid && out_stats_valid, stats_in_range)
  `RDS_ASSERT_IMPLY(a_partial_zero, clk, rst_n, out_valid && !out_stats_valid, partial_clear)

endmodule

`default_nettype wire

@@ rtl/core/rds_iter.sv @@
// ----------------------------------------------------------------------------
// Radial distance statistics shift-subtract unit
// Restoring square root (two radicand bits per step) or restoring division
// (one dividend bit per step) through one shared compare and subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module rds_iter
  import rds_pkg::*;
#(
  parameter int DIV_W = 9
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire iter_cmd_t        cmd,
  input  wire logic [SQ_W-1:0]  operand,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  busy,
  output logic [SQ_W-1:0]       result
);

  localparam int ROOT_W = SQ_W / 2;
  localparam int SUBW   = (DIV_W + 2 > ROOT_W + 3) ? DIV_W + 2 : ROOT_W + 3;

  logic              busy_r;
  logic [ITER_W-1:0] cnt_r;
  op_t               op_r;
  logic [SQ_W-1:0]   work_r;
  logic [SUBW-1:0]   rem_r;
  logic [SQ_W-1:0]   q_r;

  logic [SUBW-1:0]   rem_sh;
  logic [SUBW-1:0]   trial;
  logic [SUBW:0]     diff;
  logic              ge;
  logic [SUBW-1:0]   rem_step;
  logic [SQ_W-1:0]   work_step;

  always_comb begin
    if (op_r == OP_SQRT) begin
      rem_sh    = {rem_r[SUBW-3:0], work_r[SQ_W-1 -: 2]};
      trial     = {q_r[SUBW-3:0], 2'b01};
      work_step = {work_r[SQ_W-3:0], 2'b00};
    end else begin
      rem_sh    = {rem_r[SUBW-2:0], work_r[SQ_W-1]};
      trial     = SUBW'(divisor);
      work_step = {work_r[SQ_W-2:0], 1'b0};
    end
    diff     = {1'b0, rem_sh} - {1'b0, trial};
    ge       = ~diff[SUBW];
    rem_step = ge ? diff[SUBW-1:0] : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
      cnt_r  <= cmd.iters;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == ITER_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r   <= cmd.op;
      work_r <= operand;
      rem_r  <= '0;
      q_r    <= '0;
    end else if (busy_r) begin
      work_r <= work_step;
      rem_r  <= rem_step;
      q_r    <= {q_r[SQ_W-2:0], ge};
    end
  end

  assign busy   = busy_r;
  assign result = q_r;

endmodule

`default_nettype wire

@@ verif/radial_distance_statistics_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Radial distance statistics checker
// Watches the configuration port and both channels of the block, predicts the
// distance and the run statistics of every accepted request, and compares each
// returned result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module radial_distance_statistics_checker
  import rds_pkg::*;
#(
  parameter int MAX_ITEMS = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COORD_W-1:0]     cfg_wdata,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [COORD_W-1:0]     in_box_center_x,
  input  logic [COORD_W-1:0]     in_box_center_y,
  input  logic [SIDE_W-1:0]      in_box_width,
  input  logic [SIDE_W-1:0]      in_box_height,
  input  logic                   in_last_in,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [DIST_W-1:0]      out_distance,
  input  logic                   out_stats_valid,
  input  logic [MIN_W-1:0]       out_min_distance,
  input  logic [DIST_W-1:0]      out_max_distance,
  input  logic [DIST_W-1:0]      out_mean_distance,
  input  logic [DIST_W-1:0]      out_std_distance,
  input  logic [SIDE_W-1:0]      out_largest_side,
  input  logic [COUNT_OUT_W-1:0] out_item_count,
  input  logic                   out_overflow,
  output int                     outstanding,
  output int                     result_count,
  output int                     fail_count
);

  localparam longint unsigned SUM_SAT   = (64'd1 << SUM_W) - 1;
  localparam longint unsigned SQSUM_SAT = (64'd1 << SQSUM_W) - 1;

  typedef struct packed {
    logic [DIST_W-1:0]      distance;
    logic                   stats_valid;
    logic [MIN_W-1:0]       min_distance;
    logic [DIST_W-1:0]      max_distance;
    logic [DIST_W-1:0]      mean_distance;
    logic [DIST_W-1:0]      std_distance;
    logic [SIDE_W-1:0]      largest_side;
    logic [COUNT_OUT_W-1:0] item_count;
    logic                   overflow;
  } ellipse_stats_t;

  ellipse_stats_t       stats_q[$];
  logic [COORD_W-1:0]   centroid_x;
  logic [COORD_W-1:0]   centroid_y;
  int                   run_items;
  logic [SUM_W-1:0]     dist_sum;
  logic [SQSUM_W-1:0]   dist_sq_sum;
  logic [MIN_W-1:0]     dist_min;
  logic [DIST_W-1:0]    dist_max;
  logic [SIDE_W-1:0]    side_max;
  logic                 run_overflow;
  int                   accepted_cnt = 0;
  int                   returned_cnt = 0;
  int                   errors = 0;

  assign outstanding  = accepted_cnt - returned_cnt;
  assign result_count = returned_cnt;
  assign fail_count   = errors;

  // Bit-serial integer square root, floor of the true root.
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned probe;
    rem   = v;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  task automatic clear_run();
    run_items    = 0;
    dist_sum     = '0;
    dist_sq_sum  = '0;
    dist_min     = MIN_RESET;
    dist_max     = '0;
    side_max     = '0;
    run_overflow = 1'b0;
  endtask

  task automatic predict_ellipse(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                                 input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h,
                                 input logic last, output ellipse_stats_t res);
    longint unsigned dx, dy, radius, acc, n, mean, msq, spread, sd;
    logic [SIDE_W-1:0] side;
    dx     = (cx >= centroid_x) ? longint'(cx - centroid_x) : longint'(centroid_x - cx);
    dy     = (cy >= centroid_y) ? longint'(cy - centroid_y) : longint'(centroid_y - cy);
    radius = int_sqrt(dx * dx + dy * dy);
    side   = (w > h) ? w : h;
    mean   = 0;
    spread = 0;
    // A request past the run limit only raises the overflow flag.
    if (run_items >= MAX_ITEMS) begin
      run_overflow = 1'b1;
    end else begin
      run_items++;
      acc = longint'(dist_sum) + radius;
      dist_sum = (acc > SUM_SAT) ? SUM_SAT[SUM_W-1:0] : acc[SUM_W-1:0];
      acc = longint'(dist_sq_sum) + radius * radius;
      dist_sq_sum = (acc > SQSUM_SAT) ? SQSUM_SAT[SQSUM_W-1:0] : acc[SQSUM_W-1:0];
      if (radius < dist_min) dist_min = radius[MIN_W-1:0];
      if (radius > dist_max) dist_max = radius[DIST_W-1:0];
      if (side > side_max) side_max = side;
    end
    res = '0;
    res.distance = radius[DIST_W-1:0];
    if (last) begin
      n = longint'(run_items);
      if (n != 0) begin
        mean   = longint'(dist_sum) / n;
        msq    = longint'(dist_sq_sum) / n;
        spread = (msq > mean * mean) ? msq - mean * mean : 0;
      end
      sd = int_sqrt(spread);
      res.stats_valid   = 1'b1;
      res.min_distance  = dist_min;
      res.max_distance  = dist_max;
      res.mean_distance = mean[DIST_W-1:0];
      res.std_distance  = sd[DIST_W-1:0];
      res.largest_side  = side_max;
      res.item_count    = run_items[COUNT_OUT_W-1:0];
      res.overflow      = run_overflow;
      clear_run();
    end
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    ellipse_stats_t want;
    ellipse_stats_t fresh;
    if (!rst_n) begin
      centroid_x = '0;
      centroid_y = '0;
      clear_run();
      stats_q.delete();
      accepted_cnt <= 0;
      returned_cnt <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_CENTROID_X) centroid_x = cfg_wdata;
        if (cfg_index == REG_CENTROID_Y) centroid_y = cfg_wdata;
      end
      // Results are matched before this edge's request is queued.
      if (out_valid && !out_stall) begin
        returned_cnt <= returned_cnt + 1;
        if (stats_q.size() == 0) begin
          errors++;
          $display("%0t: result with no request pending, expected nothing, got distance %0d",
                   $time, out_distance);
        end else begin
          want = stats_q.pop_front();
          check_field("distance", want.distance, out_distance);
          check_field("stats_valid", want.stats_valid, out_stats_valid);
          check_field("min_distance", want.min_distance, out_min_distance);
          check_field("max_distance", want.max_distance, out_max_distance);
          check_field("mean_distance", want.mean_distance, out_mean_distance);
          check_field("std_distance", want.std_distance, out_std_distance);
          check_field("largest_side", want.largest_side, out_largest_side);
          check_field("item_count", want.item_count, out_item_count);
          check_field("overflow", want.overflow, out_overflow);
        end
      end
      if (in_valid && !in_stall) begin
        predict_ellipse(in_box_center_x, in_box_center_y, in_box_width, in_box_height,
                        in_last_in, fresh);
        stats_q.insert(stats_q.size(), fresh);
        accepted_cnt <= accepted_cnt + 1;
      end
    end
  end

endmodule

@@ verif/radial_distance_statistics_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Radial distance statistics testbench
// Drives runs of ellipse requests under several centroid settings, including
// runs that reach and pass the item limit, with random gaps on the request
// side and random stalls on the result side. The checker does the comparing.
// ----------------------------------------------------------------------------
module radial_distance_statistics_test;
  import rds_pkg::*;

  localparam int RUN_LIMIT   = 256;
  localparam int PHASE_ITEMS = 152;
  localparam int PHASES      = 6;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_CENTROID_X;
  logic [COORD_W-1:0]     cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [COORD_W-1:0]     in_box_center_x = '0;
  logic [COORD_W-1:0]     in_box_center_y = '0;
  logic [SIDE_W-1:0]      in_box_width = '0;
  logic [SIDE_W-1:0]      in_box_height = '0;
  logic                   in_last_in = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [DIST_W-1:0]      out_distance;
  logic                   out_stats_valid;
  logic [MIN_W-1:0]       out_min_distance;
  logic [DIST_W-1:0]      out_max_distance;
  logic [DIST_W-1:0]      out_mean_distance;
  logic [DIST_W-1:0]      out_std_distance;
  logic [SIDE_W-1:0]      out_largest_side;
  logic [COUNT_OUT_W-1:0] out_item_count;
  logic                   out_overflow;

  int outstanding;
  int result_count;
  int fail_count;

  logic [COORD_W-1:0] cur_cx = '0;
  logic [COORD_W-1:0] cur_cy = '0;
  logic               calm = 1'b0;
  int                 items_sent = 0;
  int                 runs_sent = 0;
  int                 settings_used = 1;
  int                 stall_hold = 0;

  radial_distance_statistics #(
    .MAX_ITEMS(RUN_LIMIT)
  ) u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_box_center_x(in_box_center_x), .in_box_center_y(in_box_center_y),
    .in_box_width(in_box_width), .in_box_height(in_box_height), .in_last_in(in_last_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_distance(out_distance), .out_stats_valid(out_stats_valid),
    .out_min_distance(out_min_distance), .out_max_distance(out_max_distance),
    .out_mean_distance(out_mean_distance), .out_std_distance(out_std_distance),
    .out_largest_side(out_largest_side), .out_item_count(out_item_count),
    .out_overflow(out_overflow)
  );

  radial_distance_statistics_checker #(
    .MAX_ITEMS(RUN_LIMIT)
  ) u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_box_center_x(in_box_center_x), .in_box_center_y(in_box_center_y),
    .in_box_width(in_box_width), .in_box_height(in_box_height), .in_last_in(in_last_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_distance(out_distance), .out_stats_valid(out_stats_valid),
    .out_min_distance(out_min_distance), .out_max_distance(out_max_distance),
    .out_mean_distance(out_mean_distance), .out_std_distance(out_std_distance),
    .out_largest_side(out_largest_side), .out_item_count(out_item_count),
    .out_overflow(out_overflow),
    .outstanding(outstanding), .result_count(result_count), .fail_count(fail_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #25_000_000;
    $display("Timed out with %0d results still pending", outstanding);
    $display("CHECK FAILED");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      stall_hold <= gap_len();
    end
  end

  task automatic send_ellipse(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                              input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h,
                              input logic last);
    int gap;
    gap = calm ? 0 : gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_box_center_x <= cx;
    in_box_center_y <= cy;
    in_box_width    <= w;
    in_box_height   <= h;
    in_last_in      <= last;
    in_valid        <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (last) runs_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Both registers go in back to back; called only once the block is drained.
  task automatic set_centroid(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CENTROID_X;
    cfg_wdata <= x;
    @(posedge clk);
    cfg_index <= REG_CENTROID_Y;
    cfg_wdata <= y;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_cx = x;
    cur_cy = y;
    settings_used++;
  endtask

  function automatic logic [COORD_W-1:0] near_coord(input logic [COORD_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 64)) - 32;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[COORD_W-1:0];
  endfunction

  task automatic send_random(input logic last);
    logic [COORD_W-1:0] x, y;
    logic [SIDE_W-1:0]  w, h;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 5) begin
      x = COORD_W'($urandom);
      y = COORD_W'($urandom);
    end else if (mode < 8) begin
      x = near_coord(cur_cx);
      y = near_coord(cur_cy);
    end else if (mode < 9) begin
      x = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      y = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end else begin
      x = cur_cx;
      y = cur_cy;
    end
    w = SIDE_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom);
    h = SIDE_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom);
    send_ellipse(x, y, w, h, last);
  endtask

  task automatic send_run(input int len);
    for (int i = 0; i < len; i++) send_random(i == len - 1);
  endtask

  function automatic int run_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 1;
    if (r < 85) return $urandom_range(2, 24);
    return $urandom_range(25, 60);
  endfunction

  initial begin
    int phase_start;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Centroid at its reset value: single-item run, corner points, extreme
    // sides, alternating bit patterns and a run of equal distances.
    send_ellipse(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_ellipse(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
    send_ellipse(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);
    send_ellipse(16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 1'b0);
    send_ellipse(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1);
    send_ellipse(16'd3, 16'd4, 16'd1, 16'd1, 1'b0);
    send_ellipse(16'd3, 16'd4, 16'd1, 16'd1, 1'b1);

    // Hold the requests back until the block has returned everything.
    wait_drained();
    set_centroid(16'hFFFF, 16'hFFFF);
    send_ellipse(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);
    send_ellipse(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
    send_ellipse(16'hFFFF, 16'h0000, 16'd7, 16'd9, 1'b1);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase)
        0:       set_centroid(16'h0000, 16'hFFFF);
        1:       set_centroid(16'hFFFF, 16'h0000);
        default: set_centroid(COORD_W'($urandom), COORD_W'($urandom));
      endcase
      calm = (phase == 2);
      if (phase == 3) begin
        // One run that just fills the counter, one that runs past it.
        send_run(RUN_LIMIT);
        send_run(RUN_LIMIT + 1 + $urandom_range(0, 4));
      end else begin
        phase_start = items_sent;
        while (items_sent - phase_start < PHASE_ITEMS) send_run(run_len());
      end
    end

    wait_drained();
    repeat (150) @(posedge clk);
    $display("Sent %0d ellipses in %0d runs over %0d centroid settings; %0d results compared.",
             items_sent, runs_sent, settings_used, result_count);
    $display("Runs ranged from one ellipse to past the %0d-item limit, with random stalls.",
             RUN_LIMIT);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
